>>> src/pwm_pdc_pkg.sv
// pwm_pdc_pkg: request types, control structs and constants of the pwm capture meter
// no dependencies

package pwm_pdc_pkg;

    localparam int TS_W     = 64;
    localparam int PERIOD_W = 32;
    localparam int FREQ_W   = 20;
    localparam int DUTY_W   = 16;
    localparam int PULSE_W  = 30;
    localparam int DIV_W    = PULSE_W + FREQ_W;
    localparam int STEP_W   = $clog2(DIV_W + 1);

    localparam logic [TS_W-1:0]     PULSE_LIMIT  = 64'd655360000;
    localparam logic [PERIOD_W-1:0] DUTY_DIVISOR = 32'd10000;
    localparam logic [FREQ_W-1:0]   FREQ_MAX     = '1;
    localparam logic [DUTY_W-1:0]   DUTY_MAX     = '1;

    // product at or above this gives a duty above DUTY_MAX
    localparam logic [DIV_W-1:0]    PROD_LIMIT   = 50'd655360000;
    // floor(p / 10000) == (p * DUTY_RECIP) >> RECIP_SHIFT for p below 2^PULSE_W
    localparam int                  RECIP_W      = 31;
    localparam int                  RECIP_SHIFT  = 44;
    localparam logic [RECIP_W-1:0]  DUTY_RECIP   = 31'd1759218605;

    localparam logic EDGE_RISE = 1'b0;
    localparam logic EDGE_FALL = 1'b1;

    typedef struct packed {
        logic            cmd;
        logic [TS_W-1:0] timestamp_us;
    } t_in_req;

    typedef struct packed {
        logic [PERIOD_W-1:0] period_us;
        logic [FREQ_W-1:0]   frequency_hz;
        logic [DUTY_W-1:0]   duty_percent;
        logic                duty_valid;
    } t_out_req;

    typedef struct packed {
        logic load_in;
        logic calc_diff;
        logic decide;
        logic mul;
        logic duty_wr;
        logic start_div;
        logic div_wr;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic go_div;
        logic go_mul;
        logic div_done;
        logic out_busy;
    } t_ctl_sts;

endpackage

>>> src/pwm_pdc_div.sv
// pwm_pdc_div: restoring divider, one quotient bit per cycle, dividend left-aligned
// depends on pwm_pdc_pkg

module pwm_pdc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pwm_pdc_pkg::DIV_W-1:0]  i_dividend,
    input  logic [pwm_pdc_pkg::PERIOD_W-1:0] i_divisor,
    input  logic [pwm_pdc_pkg::STEP_W-1:0] i_steps,
    output logic                           o_done,
    output logic [pwm_pdc_pkg::DIV_W-1:0]  o_quotient
);
    import pwm_pdc_pkg::*;

    logic [PERIOD_W-1:0] r_rem;
    logic [PERIOD_W-1:0] r_dsr;
    logic [DIV_W-1:0]    r_dvd;
    logic [DIV_W-1:0]    r_quo;
    logic [STEP_W-1:0]   r_cnt;
    logic                r_done;

    logic [PERIOD_W:0]   w_trial;
    logic                w_fit;
    logic [PERIOD_W:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[DIV_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= i_steps;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == STEP_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_dvd <= i_dividend;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= w_fit ? w_diff[PERIOD_W-1:0] : w_trial[PERIOD_W-1:0];
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> src/pwm_pdc_dpath.sv
// pwm_pdc_dpath: edge time state, period/pulse differences, duty product and output register
// depends on pwm_pdc_pkg and pwm_pdc_div

module pwm_pdc_dpath #(
    parameter int TIMEBASE_HZ = 1000000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pwm_pdc_pkg::t_ctl_cmd i_cmd,
    output pwm_pdc_pkg::t_ctl_sts o_sts,
    input  pwm_pdc_pkg::t_in_req  i_in_data,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output pwm_pdc_pkg::t_out_req o_out_data
);
    import pwm_pdc_pkg::*;

    localparam int TB_W = $clog2(TIMEBASE_HZ + 1);
    localparam logic [DIV_W-1:0] TB_ALIGNED = DIV_W'(TIMEBASE_HZ) << (DIV_W - TB_W);
    localparam int SCALED_W = PULSE_W + RECIP_W;

    logic                r_cmd;
    logic [TS_W-1:0]     r_ts;
    logic [TS_W-1:0]     r_diff;
    logic [DIV_W-1:0]    r_prod;
    logic [TS_W-1:0]     r_last_rise;
    logic [TS_W-1:0]     r_pulse_start;
    logic                r_rise_seen;
    logic [PERIOD_W-1:0] r_period;
    logic [FREQ_W-1:0]   r_freq;
    logic [DUTY_W-1:0]   r_duty;
    logic                r_duty_valid;
    logic                r_out_valid;
    t_out_req            r_out;

    logic [PERIOD_W-1:0] w_diff_sat;
    logic                w_pulse_big;
    logic                w_div_done;
    logic [DIV_W-1:0]    w_quo;
    logic [DIV_W-1:0]    w_prod;
    logic [SCALED_W-1:0] w_scaled;

    assign w_diff_sat  = (r_diff[TS_W-1:PERIOD_W] != '0) ? '1 : r_diff[PERIOD_W-1:0];
    assign w_pulse_big = (r_diff >= PULSE_LIMIT);
    assign w_prod      = r_diff[PULSE_W-1:0] * r_freq;
    assign w_scaled    = SCALED_W'(r_prod[PULSE_W-1:0]) * SCALED_W'(DUTY_RECIP);

    pwm_pdc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start_div),
        .i_dividend (TB_ALIGNED),
        .i_divisor  (w_diff_sat),
        .i_steps    (STEP_W'(TB_W)),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign o_sts.go_div   = (r_cmd == EDGE_RISE) && r_rise_seen && (r_diff != '0);
    assign o_sts.go_mul   = (r_cmd == EDGE_FALL) && (r_period != '0) && (r_freq != '0)
                            && !w_pulse_big;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_busy = r_out_valid && i_out_stall;

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_in_data.cmd;
            r_ts  <= i_in_data.timestamp_us;
        end
        if (i_cmd.calc_diff) begin
            r_diff <= r_ts - ((r_cmd == EDGE_FALL) ? r_pulse_start : r_last_rise);
        end
        if (i_cmd.mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.decide) begin
            if (r_cmd == EDGE_RISE) begin
                r_duty       <= '0;
                r_duty_valid <= 1'b0;
            end else begin
                r_duty_valid <= (r_period != '0);
                r_duty       <= (r_period != '0 && r_freq != '0 && w_pulse_big) ?
                                DUTY_MAX : '0;
            end
        end
        if (i_cmd.duty_wr) begin
            r_duty <= (r_prod >= PROD_LIMIT) ? DUTY_MAX : w_scaled[RECIP_SHIFT +: DUTY_W];
        end
        if (i_cmd.load_out) begin
            r_out.period_us    <= r_period;
            r_out.frequency_hz <= r_freq;
            r_out.duty_percent <= r_duty;
            r_out.duty_valid   <= r_duty_valid;
        end
    end

    // measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rise   <= '0;
            r_pulse_start <= '0;
            r_rise_seen   <= 1'b0;
            r_period      <= '0;
            r_freq        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.decide && r_cmd == EDGE_RISE) begin
                if (r_rise_seen) begin
                    r_period <= w_diff_sat;
                end
                r_last_rise   <= r_ts;
                r_pulse_start <= r_ts;
                r_rise_seen   <= 1'b1;
            end
            if (i_cmd.div_wr && r_cmd == EDGE_RISE) begin
                r_freq <= (w_quo > DIV_W'(FREQ_MAX)) ? FREQ_MAX : w_quo[FREQ_W-1:0];
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> src/pwm_pdc_ctrl.sv
// pwm_pdc_ctrl: sequencing state machine of the pwm capture meter
// depends on pwm_pdc_pkg

module pwm_pdc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pwm_pdc_pkg::t_ctl_sts i_sts,
    output pwm_pdc_pkg::t_ctl_cmd o_cmd
);
    import pwm_pdc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_DECIDE,
        S_MUL,
        S_DUTY_DIV,
        S_DIV,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DIFF;
                end
            end
            S_DIFF: begin
                o_cmd.calc_diff = 1'b1;
                n_state         = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                if (i_sts.go_div) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIV;
                end else if (i_sts.go_mul) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DUTY_DIV;
            end
            S_DUTY_DIV: begin
                o_cmd.duty_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_wr = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

>>> src/pwm_period_duty_capture_top.sv
// pwm_period_duty_capture_top: pwm period, frequency and duty meter
// depends on pwm_pdc_pkg, pwm_pdc_ctrl, pwm_pdc_dpath
//
// Input channel takes one edge request: cmd (0 rising, 1 falling) and a
// 64-bit microsecond timestamp. Output channel gives one result request
// per edge: period, frequency, duty and a duty valid flag.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low. One edge is processed at a time.
// After acceptance an edge passes the difference and decide states. A first
// rising edge, a zero-period edge or a falling edge with no duty product
// then goes to the output load; a falling edge with a duty product first
// takes a multiply, then a reciprocal multiply for the divide by 10000; a
// rising edge with a period waits for the restoring frequency divider, one
// quotient bit per cycle. The next edge is accepted in the cycle after the
// result is loaded, even while it waits. A stalled result stays in the
// output register; the block holds its next result until the register is
// free. Reset clears all measurement state and the output valid.

module pwm_period_duty_capture_top #(
    parameter int TIMEBASE_HZ = 1000000
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  pwm_pdc_pkg::t_in_req  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pwm_pdc_pkg::t_out_req o_out_data
);
    import pwm_pdc_pkg::*;

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    pwm_pdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    pwm_pdc_dpath #(
        .TIMEBASE_HZ (TIMEBASE_HZ)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> verif/tb_pwm_period_duty_capture_top.sv
// tb_pwm_period_duty_capture_top: self-checking bench for the pwm period, frequency and duty meter
// depends on pwm_pdc_pkg and pwm_period_duty_capture_top; a scoreboard class predicts each result
// directed edge cases first, then random pwm trains and noise under four idle and stall mixes

module tb_pwm_period_duty_capture_top;

    import pwm_pdc_pkg::*;

    localparam int TIMEBASE_HZ  = 1000000;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 100;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_EDGES  = 400;

    class pwm_meter_scoreboard;
        logic [TS_W-1:0]     last_rise_us   = '0;
        logic                rise_seen      = 1'b0;
        logic [TS_W-1:0]     pulse_start_us = '0;
        logic [PERIOD_W-1:0] period_us      = '0;
        logic [FREQ_W-1:0]   freq_hz        = '0;
        t_out_req            pending_q[$];
        int                  mismatches     = 0;
        int                  checked        = 0;
        int                  duty_results   = 0;

        function logic [DUTY_W-1:0] duty_from(logic [TS_W-1:0] pulse,
                                              logic [FREQ_W-1:0] freq);
            logic [TS_W-1:0] q;
            if (freq == '0) return '0;
            if (pulse >= PULSE_LIMIT) return DUTY_MAX;
            q = (pulse * 64'(freq)) / 64'(DUTY_DIVISOR);
            return (q > 64'(DUTY_MAX)) ? DUTY_MAX : q[DUTY_W-1:0];
        endfunction

        function void note_edge(t_in_req req);
            t_out_req        want;
            logic [TS_W-1:0] diff;
            logic [TS_W-1:0] quot;
            want = '0;
            if (req.cmd == EDGE_RISE) begin
                if (rise_seen) begin
                    diff = req.timestamp_us - last_rise_us;
                    period_us = (diff > 64'hFFFF_FFFF) ? '1 : diff[PERIOD_W-1:0];
                    if (period_us != '0) begin
                        quot = 64'(TIMEBASE_HZ) / 64'(period_us);
                        freq_hz = (quot > 64'(FREQ_MAX)) ? FREQ_MAX : quot[FREQ_W-1:0];
                    end
                end
                last_rise_us   = req.timestamp_us;
                rise_seen      = 1'b1;
                pulse_start_us = req.timestamp_us;
            end else if (period_us != '0) begin
                want.duty_percent = duty_from(req.timestamp_us - pulse_start_us, freq_hz);
                want.duty_valid   = 1'b1;
                duty_results++;
            end
            want.period_us    = period_us;
            want.frequency_hz = freq_hz;
            pending_q.push_back(want);
        endfunction

        function void check_result(t_out_req got);
            t_out_req want;
            checked++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result %0d with nothing pending: ",
                              "period=%0d freq=%0d duty=%0d valid=%0b"},
                             checked, got.period_us, got.frequency_hz, got.duty_percent,
                             got.duty_valid);
                return;
            end
            want = pending_q.pop_front();
            if (got.period_us !== want.period_us || got.frequency_hz !== want.frequency_hz ||
                got.duty_percent !== want.duty_percent || got.duty_valid !== want.duty_valid) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"result %0d: exp period=%0d freq=%0d duty=%0d valid=%0b, ",
                              "got period=%0d freq=%0d duty=%0d valid=%0b"},
                             checked, want.period_us, want.frequency_hz, want.duty_percent,
                             want.duty_valid, got.period_us, got.frequency_hz,
                             got.duty_percent, got.duty_valid);
            end
        endfunction
    endclass

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    t_in_req  req_data  = '0;
    logic     res_valid;
    logic     res_stall = 1'b0;
    t_out_req res_data;

    pwm_meter_scoreboard sb;
    int              idle_pct    = 0;
    int              stall_pct   = 0;
    int              sent_count  = 0;
    int              cycle_count = 0;
    logic [TS_W-1:0] now_us      = '0;

    pwm_period_duty_capture_top #(
        .TIMEBASE_HZ(TIMEBASE_HZ)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (req_valid),
        .o_in_stall (req_stall),
        .i_in_data  (req_data),
        .o_out_valid(res_valid),
        .i_out_stall(res_stall),
        .o_out_data (res_data)
    );

    always #5 clk = ~clk;

    always @(negedge clk) begin
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && !res_stall) sb.check_result(res_data);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     sb.pending_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_edge(input logic cmd, input logic [TS_W-1:0] ts);
        t_in_req req;
        req.cmd          = cmd;
        req.timestamp_us = ts;
        while ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= req;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sb.note_edge(req);
        sent_count++;
        now_us = ts;
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic run_phase(input int send_idle, input int recv_stall, input int n_edges);
        logic [TS_W-1:0] per;
        logic [TS_W-1:0] hi;
        logic [TS_W-1:0] t;
        int              pick;
        int              stop_at;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        stop_at   = sent_count + n_edges;
        while (sent_count < stop_at) begin
            if ($urandom_range(99) < 80) begin
                // pwm train with random period, duty and start time, at times with a pulse longer than the period
                pick = $urandom_range(99);
                if (pick < 35) per = 64'($urandom_range(1, 200));
                else if (pick < 70) per = 64'($urandom_range(201, 100000));
                else if (pick < 85) per = 64'($urandom_range(100001, 3000000));
                else if (pick < 93) per = {32'b0, $urandom()};
                else per = {24'b0, 8'($urandom_range(1, 255)), $urandom()};
                case ($urandom_range(3))
                    0: t = now_us + per;
                    1: t = {$urandom(), $urandom()};
                    2: t = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 4000));
                    default: t = now_us + 64'($urandom_range(0, 50));
                endcase
                repeat ($urandom_range(2, 8)) begin
                    if ($urandom_range(9) == 0) hi = per + per * 64'($urandom_range(1, 9));
                    else hi = (per * 64'($urandom_range(0, 100))) / 64'd100;
                    send_edge(EDGE_RISE, t);
                    send_edge(EDGE_FALL, t + hi);
                    t = t + 64'd1 * per;
                    // small jitter on the period
                    pick = $urandom_range(7);
                    if (pick == 0) t = t + 64'd1;
                    else if (pick == 1 && per > 64'd2) t = t - 64'd1;
                end
            end else begin
                case ($urandom_range(4))
                    0: send_edge(1'($urandom_range(1)), {$urandom(), $urandom()});
                    1: send_edge(EDGE_RISE, now_us);
                    2: send_edge(EDGE_FALL, now_us + 64'($urandom_range(0, 1000000)));
                    3: send_edge(EDGE_FALL,
                                 now_us + ({$urandom(), $urandom()} >> $urandom_range(20, 63)));
                    default: send_edge(1'($urandom_range(1)),
                                       now_us - 64'($urandom_range(1, 100)));
                endcase
            end
        end
        drain_results();
    endtask

    initial begin
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // no period yet, zero timestamps, zero period
        send_edge(EDGE_FALL, 64'd5);
        send_edge(EDGE_RISE, 64'd0);
        send_edge(EDGE_FALL, 64'd3);
        send_edge(EDGE_RISE, 64'd0);
        send_edge(EDGE_RISE, 64'd1000);
        send_edge(EDGE_FALL, 64'd1250);
        send_edge(EDGE_RISE, 64'd1000);
        send_edge(EDGE_FALL, 64'd1100);
        // one microsecond period, duty overflow
        send_edge(EDGE_RISE, 64'd1001);
        send_edge(EDGE_FALL, 64'd1001);
        send_edge(EDGE_RISE, 64'd1002);
        send_edge(EDGE_FALL, 64'd1702);
        // frequency rounds to zero, long period saturates
        send_edge(EDGE_RISE, 64'd2001002);
        send_edge(EDGE_FALL, 64'd2001502);
        send_edge(EDGE_RISE, 64'h0000_0100_0000_0000);
        send_edge(EDGE_RISE, 64'hFFFF_FFFF_FFFF_FFF0);
        // time wrap on period and pulse
        send_edge(EDGE_RISE, 64'h0000_0000_0000_0010);
        send_edge(EDGE_FALL, 64'h0000_0000_0000_0020);
        send_edge(EDGE_FALL, 64'h0000_0000_0000_0010 + PULSE_LIMIT);
        send_edge(EDGE_FALL, 64'h0000_0000_0000_000F);
        send_edge(EDGE_RISE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_edge(EDGE_RISE, 64'h0000_0000_0000_0000);
        send_edge(EDGE_FALL, 64'd655);
        send_edge(EDGE_RISE, 64'hAAAA_AAAA_5555_5555);
        send_edge(EDGE_FALL, 64'h5555_5555_AAAA_AAAA);
        drain_results();

        run_phase(0, 0, PHASE_EDGES);
        run_phase(52, 0, PHASE_EDGES);
        run_phase(0, 52, PHASE_EDGES);
        run_phase(27, 27, PHASE_EDGES);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display({"covered %0d edges under four idle/stall mixes: ",
                  "%0d results checked, %0d with a duty"},
                 sent_count, sb.checked, sb.duty_results);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/pwm_pdc_pkg.sv
src/pwm_pdc_div.sv
src/pwm_pdc_dpath.sv
src/pwm_pdc_ctrl.sv
src/pwm_period_duty_capture_top.sv
verif/tb_pwm_period_duty_capture_top.sv
